// File: hdl/tmcw_pkg.sv
package tmcw_pkg;

	// payload field widths
	localparam int FUNC_W = 3;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int POS_W  = 11;
	localparam int CELL_W = CHAR_W + ATTR_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'd1;

	localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
	localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_PUT       = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUT_AT    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_BACKSPACE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ      = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd4;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
	localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_E       = 8'h45;

endpackage

// File: hdl/tmcw_in_if.sv
interface tmcw_in_if;
	import tmcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [CHAR_W-1:0] char_code;
	logic [ATTR_W-1:0] attr_in;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;

	modport source (output valid, func, char_code, attr_in, col, row, input ready);
	modport sink   (input valid, func, char_code, attr_in, col, row, output ready);
endinterface

// File: hdl/tmcw_out_if.sv
interface tmcw_out_if;
	import tmcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] read_char;
	logic [ATTR_W-1:0] read_attr;
	logic [POS_W-1:0]  cursor_pos;
	logic              coord_error;

	modport source (output valid, read_char, read_attr, cursor_pos, coord_error, input ready);
	modport sink   (input valid, read_char, read_attr, cursor_pos, coord_error, output ready);
endinterface

// File: hdl/text_mode_console_writer_top.sv
// Channel  Dir  Transfer when     Payload
// in_ch    in   valid && ready    func, char_code, attr_in, col, row
// out_ch   out  valid && ready    read_char, read_attr, cursor_pos, coord_error
// cfg      in   cfg_we            cfg_idx, cfg_data (write only)
//
// Put, backspace, bad-coordinate and undefined operations pass through S_WRITE; a read
// passes S_READ and S_EMIT. A put that scrolls first blanks the recycled row, and a clear
// sweeps every cell. Both sweeps go through the single cell-memory write port.
// After reset a clearing pass zeroes the memory, and in_ch.ready stays low meanwhile.
// A result waiting on out_ch holds the block after the next item.
module text_mode_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tmcw_in_if.sink                         in_ch,
	tmcw_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [tmcw_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tmcw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tmcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int TW    = $clog2(ROWS);
	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	localparam logic [LW-1:0] COLS_L  = LW'(COLUMNS);
	localparam logic [AW-1:0] COLS_A  = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_A  = AW'(CELLS - 1);
	localparam logic [RW-1:0] ROWS_R  = RW'(ROWS);
	localparam logic [RW-1:0] LROW_R  = RW'(ROWS - 1);
	localparam logic [RW:0]   ROWS_S  = (RW + 1)'(ROWS);
	localparam logic [TW-1:0] LROW_T  = TW'(ROWS - 1);
	localparam logic [CW-1:0] LCOL_C  = CW'(COLUMNS - 1);
	localparam logic [7:0]    COLS_8  = 8'(COLUMNS);
	localparam logic [5:0]    ROWS_6  = 6'(ROWS);

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_SWEEP, S_WRITE, S_READ, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CM_KEEP, CM_SET, CM_PUT
	} cmode_t;

	state_t              state_q;
	cmode_t              cmode_q;
	logic [AW-1:0]       swp_q, swp_last_q;
	logic [CELL_W-1:0]   swp_data_q;
	logic                swp_scroll_q;
	logic [TW-1:0]       top_q;
	logic [RW-1:0]       cur_row_q, wr_row_q;
	logic [CW-1:0]       cur_col_q, wr_col_q;
	logic [LW-1:0]       cur_lin_q;
	logic [CELL_W-1:0]   wdata_q;
	logic                we_q, is_read_q, err_q;
	logic [CHAR_W-1:0]   code_q;
	logic [ATTR_W-1:0]   default_attr_q, error_attr_q;

	logic                out_valid_q, out_err_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic [ATTR_W-1:0]   out_attr_q;
	logic [POS_W-1:0]    out_pos_q;

	logic [CELL_W-1:0]   mem [CELLS];
	logic [CELL_W-1:0]   rdata_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= DEFAULT_ATTR_RST;
			error_attr_q   <= ERROR_ATTR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEFAULT_ATTR: default_attr_q <= cfg_data;
				REG_ERROR_ATTR:   error_attr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode
	logic              in_bad, in_fire;
	logic [ATTR_W-1:0] in_attr;
	logic [CHAR_W-1:0] in_char;
	logic [AW-1:0]     top_base;
	logic [RW-1:0]     bs_row;
	logic [CW-1:0]     bs_col;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign in_bad   = (8'(in_ch.col) >= COLS_8) || (6'(in_ch.row) >= ROWS_6);
	assign in_attr  = (in_ch.attr_in == '0) ? default_attr_q : in_ch.attr_in;
	assign in_char  = (in_ch.char_code == CH_BS) ? CH_SPACE : in_ch.char_code;
	assign top_base = AW'(top_q) * COLS_A;

	// backspace target: previous cell, or stay at cell zero
	always_comb begin
		bs_row = cur_row_q;
		bs_col = cur_col_q;
		if (cur_col_q != '0) begin
			bs_col = cur_col_q - CW'(1);
		end else if (cur_row_q != '0) begin
			bs_row = cur_row_q - RW'(1);
			bs_col = LCOL_C;
		end
	end

	// logical row to physical row through the top-row ring offset
	logic [RW:0]   prow_sum;
	logic [RW-1:0] prow;
	logic [AW-1:0] phys_addr;
	logic [LW-1:0] wr_lin;

	assign prow_sum  = (RW + 1)'(wr_row_q) + (RW + 1)'(top_q);
	assign prow      = (prow_sum >= ROWS_S) ? RW'(prow_sum - ROWS_S) : RW'(prow_sum);
	assign phys_addr = AW'(prow) * COLS_A + AW'(wr_col_q);
	assign wr_lin    = LW'(wr_row_q) * COLS_L + LW'(wr_col_q);

	// cursor after the current operation
	logic [RW-1:0] nx_row;
	logic [CW-1:0] nx_col;
	logic [LW-1:0] nx_lin;

	always_comb begin
		nx_row = cur_row_q;
		nx_col = cur_col_q;
		nx_lin = cur_lin_q;
		case (cmode_q)
			CM_SET: begin
				nx_row = wr_row_q;
				nx_col = wr_col_q;
				nx_lin = wr_lin;
			end
			CM_PUT: begin
				if (code_q == CH_NL) begin
					nx_row = wr_row_q + RW'(1);
					nx_col = '0;
					nx_lin = LW'(wr_row_q + RW'(1)) * COLS_L;
				end else if (code_q == CH_BS) begin
					nx_row = wr_row_q;
					nx_col = wr_col_q;
					nx_lin = wr_lin;
				end else if (wr_col_q == LCOL_C) begin
					nx_row = wr_row_q + RW'(1);
					nx_col = '0;
					nx_lin = wr_lin + LW'(1);
				end else begin
					nx_row = wr_row_q;
					nx_col = wr_col_q + CW'(1);
					nx_lin = wr_lin + LW'(1);
				end
			end
			default: ;
		endcase
	end

	// memory port control
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              out_free;

	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = phys_addr;
		mem_wdata = wdata_q;
		mem_re    = (state_q == S_READ);
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = swp_q;
				mem_wdata = '0;
			end
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = swp_q;
				mem_wdata = swp_data_q;
			end
			S_WRITE: mem_we = we_q;
			default: ;
		endcase
	end

	// cell memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_s1 <= mem[phys_addr];
	end

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cmode_q      <= CM_KEEP;
			swp_q        <= '0;
			swp_last_q   <= LAST_A;
			swp_data_q   <= '0;
			swp_scroll_q <= 1'b0;
			top_q        <= '0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cur_lin_q    <= '0;
			we_q         <= 1'b0;
			is_read_q    <= 1'b0;
			err_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_INIT: begin
					swp_q <= swp_q + AW'(1);
					if (swp_q == swp_last_q)
						state_q <= S_IDLE;
				end

				S_IDLE: begin
					if (in_fire) begin
						we_q      <= 1'b0;
						cmode_q   <= CM_KEEP;
						is_read_q <= 1'b0;
						err_q     <= 1'b0;
						code_q    <= in_ch.char_code;
						wdata_q   <= {in_attr, in_char};
						state_q   <= S_WRITE;
						case (in_ch.func)
							FN_PUT: begin
								wr_row_q <= cur_row_q;
								wr_col_q <= cur_col_q;
								cmode_q  <= CM_PUT;
								we_q     <= (in_ch.char_code != CH_NL);
								// cursor past the end: blank the top row, it becomes the last
								if (cur_row_q == ROWS_R) begin
									swp_q        <= top_base;
									swp_last_q   <= top_base + COLS_A - AW'(1);
									swp_data_q   <= '0;
									swp_scroll_q <= 1'b1;
									state_q      <= S_SWEEP;
								end
							end
							FN_PUT_AT: begin
								if (in_bad) begin
									wr_row_q <= LROW_R;
									wr_col_q <= LCOL_C;
									we_q     <= 1'b1;
									wdata_q  <= {error_attr_q, CH_E};
									err_q    <= 1'b1;
								end else begin
									wr_row_q <= RW'(in_ch.row);
									wr_col_q <= CW'(in_ch.col);
									cmode_q  <= CM_PUT;
									we_q     <= (in_ch.char_code != CH_NL);
								end
							end
							FN_BACKSPACE: begin
								wr_row_q <= bs_row;
								wr_col_q <= bs_col;
								we_q     <= 1'b1;
								wdata_q  <= {default_attr_q, CH_SPACE};
								cmode_q  <= CM_SET;
							end
							FN_READ: begin
								if (in_bad) begin
									err_q <= 1'b1;
								end else begin
									wr_row_q  <= RW'(in_ch.row);
									wr_col_q  <= CW'(in_ch.col);
									is_read_q <= 1'b1;
									state_q   <= S_READ;
								end
							end
							FN_CLEAR: begin
								swp_q        <= '0;
								swp_last_q   <= LAST_A;
								swp_data_q   <= {default_attr_q, CH_SPACE};
								swp_scroll_q <= 1'b0;
								top_q        <= '0;
								cur_row_q    <= '0;
								cur_col_q    <= '0;
								cur_lin_q    <= '0;
								state_q      <= S_SWEEP;
							end
							default: ;
						endcase
					end
				end

				S_SWEEP: begin
					swp_q <= swp_q + AW'(1);
					if (swp_q == swp_last_q) begin
						state_q <= S_WRITE;
						if (swp_scroll_q) begin
							top_q    <= (top_q == LROW_T) ? '0 : top_q + TW'(1);
							wr_row_q <= LROW_R;
							wr_col_q <= '0;
						end
					end
				end

				S_WRITE: begin
					cur_row_q <= nx_row;
					cur_col_q <= nx_col;
					cur_lin_q <= nx_lin;
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= '0;
						out_attr_q  <= '0;
						out_pos_q   <= POS_W'(nx_lin);
						out_err_q   <= err_q;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end

				S_READ: state_q <= S_EMIT;

				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= is_read_q ? rdata_s1[CHAR_W-1:0] : '0;
						out_attr_q  <= is_read_q ? rdata_s1[CELL_W-1:CHAR_W] : '0;
						out_pos_q   <= POS_W'(cur_lin_q);
						out_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.read_char   = out_char_q;
	assign out_ch.read_attr   = out_attr_q;
	assign out_ch.cursor_pos  = out_pos_q;
	assign out_ch.coord_error = out_err_q;

	// linear cursor tracks row and column
	a_cursor_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		cur_lin_q == LW'(cur_row_q) * COLS_L + LW'(cur_col_q))
		else $error("linear cursor out of step with row/column");

	// past the last row the cursor sits at column zero
	a_cursor_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q >= ROWS_R) |-> (cur_row_q == ROWS_R && cur_col_q == '0))
		else $error("cursor beyond end of grid");

	// ring offset stays inside the grid
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= LROW_T)
		else $error("top row offset out of range");

	// a read state is always followed by the result stage
	a_read_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_EMIT && is_read_q))
		else $error("read not followed by result stage");

endmodule

// File: sim/console_reply_checker.sv
module console_reply_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tmcw_in_if                              in_mon,
	tmcw_out_if                             out_mon,
	input  logic                            cfg_we,
	input  logic [tmcw_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tmcw_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              outstanding,
	output int                              checked_count,
	output int                              scroll_count,
	output int                              error_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import tmcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [CHAR_W-1:0] rd_char;
		logic [ATTR_W-1:0] rd_attr;
		logic [POS_W-1:0]  cursor;
		logic              err;
	} reply_t;

	// shadow copy of the console
	logic [CELL_W-1:0] grid [CELLS];
	int                cursor;
	logic [ATTR_W-1:0] dflt_attr;
	logic [ATTR_W-1:0] err_attr;
	reply_t            pending_replies [$];

	function automatic void reset_console();
		for (int i = 0; i < CELLS; i++)
			grid[i] = '0;
		cursor        = 0;
		dflt_attr     = DEFAULT_ATTR_RST;
		err_attr      = ERROR_ATTR_RST;
		fail_count    = 0;
		outstanding   = 0;
		checked_count = 0;
		scroll_count  = 0;
		error_count   = 0;
		pending_replies.delete();
	endfunction

	// places code at pos (newline writes nothing), scrolling first when past the end
	function automatic int place_char(input int pos, input logic [CHAR_W-1:0] code,
			input logic [ATTR_W-1:0] attr);
		int p;
		p = pos;
		if (p >= CELLS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				grid[i] = grid[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				grid[i] = '0;
			p = CELLS - COLUMNS;
			scroll_count++;
		end
		if (code == CH_NL) begin
			p = (p / COLUMNS + 1) * COLUMNS;
		end else if (code == CH_BS) begin
			grid[p] = {attr, CH_SPACE};
		end else begin
			grid[p] = {attr, code};
			p++;
		end
		return p;
	endfunction

	// applies one console operation to the shadow state, returns the reply it causes
	function automatic reply_t apply_console_op(input logic [FUNC_W-1:0] fn,
			input logic [CHAR_W-1:0] code, input logic [ATTR_W-1:0] attr_raw,
			input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
		reply_t            rep;
		logic [ATTR_W-1:0] attr;
		bit                bad;
		int                cell_idx;
		rep      = '0;
		attr     = (attr_raw == '0) ? dflt_attr : attr_raw;
		bad      = (int'(c) >= COLUMNS) || (int'(r) >= ROWS);
		cell_idx = int'(r) * COLUMNS + int'(c);
		if (cursor > CELLS)
			cursor = CELLS;
		case (fn)
			FN_PUT: cursor = place_char(cursor, code, attr);
			FN_PUT_AT: begin
				if (bad) begin
					grid[CELLS-1] = {err_attr, CH_E};
					rep.err = 1'b1;
				end else begin
					cursor = place_char(cell_idx, code, attr);
				end
			end
			FN_BACKSPACE: begin
				if (cursor > 0)
					cursor--;
				grid[cursor] = {dflt_attr, CH_SPACE};
			end
			FN_READ: begin
				if (bad)
					rep.err = 1'b1;
				else
					{rep.rd_attr, rep.rd_char} = grid[cell_idx];
			end
			FN_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					grid[i] = {dflt_attr, CH_SPACE};
				cursor = 0;
			end
			default: ;
		endcase
		rep.cursor = cursor[POS_W-1:0];
		if (rep.err)
			error_count++;
		return rep;
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial reset_console();

	// watch the channels: check the outgoing transfer, then predict the incoming one
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			reset_console();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_DEFAULT_ATTR: dflt_attr = cfg_data;
					REG_ERROR_ATTR:   err_attr  = cfg_data;
					default: ;
				endcase
			end
			if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: result with no pending expectation, cursor_pos %0d",
						$time, out_mon.cursor_pos);
					fail_count++;
				end else begin
					want = pending_replies.pop_front();
					compare_field("read_char", 16'(want.rd_char), 16'(out_mon.read_char));
					compare_field("read_attr", 16'(want.rd_attr), 16'(out_mon.read_attr));
					compare_field("cursor_pos", 16'(want.cursor), 16'(out_mon.cursor_pos));
					compare_field("coord_error", 16'(want.err), 16'(out_mon.coord_error));
					checked_count++;
				end
			end
			if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
				pending_replies.push_back(apply_console_op(in_mon.func, in_mon.char_code,
					in_mon.attr_in, in_mon.col, in_mon.row));
			outstanding = pending_replies.size();
		end
	end

endmodule

// File: sim/text_mode_console_writer_top_tb.sv
module text_mode_console_writer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tmcw_pkg::*;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = COLUMNS * ROWS;
	localparam int PHASE_ITEMS = 300;
	localparam int MAX_IDLE    = 64;

	localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 3'd5;

	// worst case per transfer: a clear or a scroll, plus the longest gap and stall
	localparam longint CYCLE_LIMIT =
		4 * (longint'(25 + 4 * PHASE_ITEMS) * (CELLS + COLUMNS + 3 + 2 * MAX_IDLE) + CELLS);

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	tmcw_in_if  in_ch ();
	tmcw_out_if out_ch ();

	int     fail_count;
	int     outstanding;
	int     checked_count;
	int     scroll_count;
	int     error_count;
	int     n_sent;
	int     n_settings;
	bit     steady;
	longint cycle_count;

	text_mode_console_writer_top #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	console_reply_checker #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.scroll_count  (scroll_count),
		.error_count   (error_count)
	);

	always #5ns clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side backpressure
	always @(negedge clk) begin
		out_ch.ready <= steady || ($urandom_range(99) >= 30);
	end

	// one input transfer; entered and left just after a falling edge
	task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
			input logic [ATTR_W-1:0] at, input logic [COL_W-1:0] c,
			input logic [ROW_W-1:0] r, input bit drain_first);
		bit gap;
		gap = !steady && ($urandom_range(99) < 30);
		if (gap || drain_first) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
			while (drain_first && outstanding != 0)
				@(negedge clk);
			while (!steady && $urandom_range(99) < 30)
				@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.func      <= fn;
		in_ch.char_code <= ch;
		in_ch.attr_in   <= at;
		in_ch.col       <= c;
		in_ch.row       <= r;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// stop sending and wait until every expected result is back and the block settles
	task automatic drain_idle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (COLUMNS + 4) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [ATTR_W-1:0] dflt, input logic [ATTR_W-1:0] err);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_DEFAULT_ATTR;
		cfg_data <= dflt;
		@(negedge clk);
		cfg_idx  <= REG_ERROR_ATTR;
		cfg_data <= err;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		n_settings++;
	endtask

	// mostly printable text, with line control and the odd raw byte
	function automatic logic [CHAR_W-1:0] pick_char();
		int p;
		p = $urandom_range(99);
		if (p < 85)
			return CHAR_W'($urandom_range(126, 32));
		else if (p < 92)
			return CH_NL;
		else if (p < 97)
			return CH_BS;
		return CHAR_W'($urandom_range(255));
	endfunction

	// a position biased toward the bottom row, out of range now and then
	task automatic pick_position(output logic [COL_W-1:0] c, output logic [ROW_W-1:0] r,
			input int bad_pct);
		if ($urandom_range(99) < bad_pct) begin
			c = COL_W'($urandom_range(127));
			r = ROW_W'($urandom_range(31));
			if ($urandom_range(1))
				c = COL_W'($urandom_range(127, COLUMNS));
			else
				r = ROW_W'($urandom_range(31, ROWS));
		end else begin
			c = COL_W'($urandom_range(COLUMNS - 1));
			r = $urandom_range(1) ? ROW_W'(ROWS - 1) : ROW_W'($urandom_range(ROWS - 1));
		end
	endtask

	task automatic random_op();
		logic [FUNC_W-1:0] fn;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] at;
		logic [COL_W-1:0]  c;
		logic [ROW_W-1:0]  r;
		int                pick;
		pick = $urandom_range(99);
		ch   = CHAR_W'($urandom_range(255));
		at   = ATTR_W'($urandom_range(255));
		c    = COL_W'($urandom_range(127));
		r    = ROW_W'($urandom_range(31));
		if (pick < 40) begin
			fn = FN_PUT;
			ch = pick_char();
			if ($urandom_range(3) == 0)
				at = '0;
		end else if (pick < 55) begin
			fn = FN_PUT_AT;
			ch = pick_char();
			if ($urandom_range(3) == 0)
				at = '0;
			pick_position(c, r, 15);
		end else if (pick < 67) begin
			fn = FN_BACKSPACE;
		end else if (pick < 92) begin
			fn = FN_READ;
			pick_position(c, r, 10);
		end else if (pick < 93) begin
			fn = FN_CLEAR;
		end else if (pick < 97) begin
			fn = FN_FIRST_UNUSED + FUNC_W'($urandom_range(2));
		end else begin
			fn = FUNC_W'($urandom_range(7));
		end
		send_op(fn, ch, at, c, r, $urandom_range(199) == 0);
	endtask

	task automatic run_phase(input logic [ATTR_W-1:0] dflt, input logic [ATTR_W-1:0] err,
			input bit steady_phase);
		drain_idle();
		apply_setting(dflt, err);
		steady = steady_phase;
		repeat (PHASE_ITEMS) random_op();
		steady = 1'b0;
	endtask

	initial begin
		in_ch.valid     = 1'b0;
		in_ch.func      = FN_PUT;
		in_ch.char_code = '0;
		in_ch.attr_in   = '0;
		in_ch.col       = '0;
		in_ch.row       = '0;
		out_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = REG_DEFAULT_ATTR;
		cfg_data        = '0;
		steady          = 1'b0;
		n_sent          = 0;
		n_settings      = 0;
		cycle_count     = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fresh grid, puts, newline and blank, backspace
		send_op(FN_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
		send_op(FN_PUT, "A", 8'h00, 7'd0, 5'd0, 1'b0);
		send_op(FN_PUT, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b0);
		send_op(FN_PUT, CH_BS, 8'h12, 7'd0, 5'd0, 1'b0);
		send_op(FN_PUT, CH_NL, 8'h00, 7'd0, 5'd0, 1'b0);
		send_op(FN_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
		send_op(FN_READ, 8'h00, 8'h00, 7'd79, 5'd0, 1'b0);
		// last cell, then scrolling on put, newline and blank
		send_op(FN_PUT_AT, "Z", 8'h00, 7'd79, 5'd24, 1'b0);
		send_op(FN_PUT, 8'h00, 8'h01, 7'd0, 5'd0, 1'b0);
		send_op(FN_PUT_AT, CH_NL, 8'h80, 7'd0, 5'd24, 1'b0);
		send_op(FN_PUT, CH_NL, 8'h00, 7'd0, 5'd0, 1'b0);
		send_op(FN_PUT, CH_BS, 8'h7F, 7'd0, 5'd0, 1'b0);
		// out-of-range coordinates
		send_op(FN_PUT_AT, "x", 8'h00, 7'd127, 5'd0, 1'b0);
		send_op(FN_PUT_AT, "x", 8'h00, 7'd80, 5'd24, 1'b0);
		send_op(FN_PUT_AT, "x", 8'h00, 7'd0, 5'd31, 1'b0);
		send_op(FN_PUT_AT, "x", 8'h00, 7'd0, 5'd25, 1'b0);
		send_op(FN_READ, 8'h00, 8'h00, 7'd79, 5'd24, 1'b0);
		send_op(FN_READ, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b0);
		send_op(FN_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
		// unused operation codes
		send_op(FN_FIRST_UNUSED, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b0);
		send_op(FN_FIRST_UNUSED + 3'd1, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
		send_op('1, 8'h55, 8'hAA, 7'd42, 5'd21, 1'b0);
		// clear, then backspace at cell zero
		send_op(FN_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
		send_op(FN_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
		send_op(FN_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);

		// random phases over attribute settings, extremes first
		run_phase(8'h00, 8'hFF, 1'b0);
		run_phase(8'hFF, 8'h00, 1'b0);
		run_phase(ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), 1'b1);
		run_phase(ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), 1'b0);

		drain_idle();
		$display("Ran %0d transfers under %0d attribute settings, %0d results checked",
			n_sent, n_settings + 1, checked_count);
		$display("Grid scrolled %0d times, %0d coordinate errors predicted",
			scroll_count, error_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
